[src/plc_pkg.sv]
// package for the priority layer pixel compositor
// transaction structs, register codes and pixel field constants; no dependencies
package plc_pkg;

    localparam int unsigned PixelW = 32;
    localparam int unsigned MaxLayers = 8;

    // configuration register indexes
    localparam logic [1:0] RegBlendMode = 2'd0;
    localparam logic [1:0] RegOutFormat = 2'd1;

    // blend modes
    localparam logic [1:0] ModeAlphaTop = 2'd0;
    localparam logic [1:0] ModeAlphaBot = 2'd1;
    localparam logic [1:0] ModeSatAdd = 2'd2;

    // display formats
    localparam logic [1:0] FmtArgb8888 = 2'd0;
    localparam logic [1:0] FmtRgb555 = 2'd1;
    localparam logic [1:0] FmtRgb565 = 2'd2;

    localparam logic [5:0] AlphaFull = 6'h3F;

    typedef struct packed {
        logic [31:0] layer0_pixel;
        logic [31:0] layer1_pixel;
        logic [31:0] layer2_pixel;
        logic [31:0] layer3_pixel;
        logic [31:0] layer4_pixel;
        logic [31:0] layer5_pixel;
        logic [31:0] layer6_pixel;
        logic [31:0] layer7_pixel;
    } t_in;

    typedef struct packed {
        logic [31:0] composed_pixel;
        logic [31:0] display_pixel;
        logic        pixel_present;
    } t_out;

endpackage

[src/priority_layer_pixel_compositor_top.sv]
// priority layer pixel compositor: start reaches o_valid through a valid register per layer, then the output register
// throughput one transaction per cycle, busy is always low; one lane per layer above the background,
// each stage registered, chained from background to top, then a display conversion stage
// synchronous active-low reset clears the valid pipeline and both config registers
// the receiver cannot stall; depends on plc_pkg and plc_lane
module priority_layer_pixel_compositor_top #(
    parameter int unsigned NUM_LAYERS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  plc_pkg::t_in  i_data,
    output logic          o_valid,
    output plc_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [1:0]    i_cfg_data
);
    import plc_pkg::*;

    logic [1:0]  r_mode;
    logic [1:0]  r_fmt;
    logic [31:0] in_lay [MaxLayers];
    logic [31:0] r_lay  [NUM_LAYERS][NUM_LAYERS];
    logic [31:0] r_acc  [NUM_LAYERS];
    logic [31:0] n_acc  [NUM_LAYERS];
    logic        r_vld  [NUM_LAYERS];
    logic        r_ovld;
    t_out        r_out;
    t_out        n_out;

    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeAlphaTop;
            r_fmt  <= FmtArgb8888;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == RegBlendMode) r_mode <= i_cfg_data;
            if (i_cfg_idx == RegOutFormat) r_fmt <= i_cfg_data;
        end
    end

    // unpack the input transaction
    assign in_lay[0] = i_data.layer0_pixel;
    assign in_lay[1] = i_data.layer1_pixel;
    assign in_lay[2] = i_data.layer2_pixel;
    assign in_lay[3] = i_data.layer3_pixel;
    assign in_lay[4] = i_data.layer4_pixel;
    assign in_lay[5] = i_data.layer5_pixel;
    assign in_lay[6] = i_data.layer6_pixel;
    assign in_lay[7] = i_data.layer7_pixel;

    // background stage
    assign n_acc[0] = in_lay[0];

    // one lane per layer above the background
    for (genvar k = 1; k < NUM_LAYERS; k++) begin : g_lane
        plc_lane u_lane (
            .i_pixel (r_lay[k-1][k]),
            .i_below (r_acc[k-1]),
            .i_mode  (r_mode),
            .o_pixel (n_acc[k])
        );
    end

    // pipeline registers
    for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= (k == 0) ? (start && !busy) : r_vld[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            r_acc[k] <= n_acc[k];
            for (int j = 0; j < NUM_LAYERS; j++) begin
                r_lay[k][j] <= (k == 0) ? in_lay[j] : r_lay[(k == 0) ? 0 : k-1][j];
            end
        end
    end

    // display conversion
    always_comb begin
        logic [31:0] p;
        p = r_acc[NUM_LAYERS-1];
        n_out.composed_pixel = p;
        n_out.pixel_present  = (p != '0);
        case (r_fmt)
            FmtRgb555: n_out.display_pixel = {17'd0, p[23:19], p[15:11], p[7:3]};
            FmtRgb565: n_out.display_pixel = {16'd0, p[23:19], p[15:10], p[7:3]};
            default:   n_out.display_pixel = {p[29:24], 2'b11, p[23:0]};
        endcase
        if (!n_out.pixel_present) n_out.display_pixel = '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[NUM_LAYERS-1];
        end
        r_out <= n_out;
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

`ifndef SYNTH
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.pixel_present == (o_data.composed_pixel != '0)))
        else $error("present flag disagrees with composite");
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.pixel_present) |-> (o_data.display_pixel == '0))
        else $error("display pixel not zero when absent");
    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_LAYERS-1] |=> o_valid)
        else $error("result lost at output stage");
`endif

endmodule

[src/plc_lane.sv]
// one layer lane: puts a layer pixel over the composite of the layers below
// depends on plc_pkg
module plc_lane (
    input  logic [31:0] i_pixel,
    input  logic [31:0] i_below,
    input  logic [1:0]  i_mode,
    output logic [31:0] o_pixel
);
    import plc_pkg::*;

    logic       transp;
    logic [7:0] w;
    logic [5:0] a_out;
    logic [7:0] wch [3];
    logic [7:0] sch [3];

    // division by 255 for products up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // transparency test per mode
    always_comb begin
        if (i_mode == ModeAlphaBot || i_mode == ModeSatAdd) begin
            transp = i_pixel[31];
        end else begin
            transp = (i_pixel[29:24] != AlphaFull);
        end
    end

    // blend weight and result alpha
    always_comb begin
        if (i_mode == ModeAlphaBot) begin
            w     = {i_below[29:24], 2'b11};
            a_out = i_pixel[29:24];
        end else begin
            w     = {i_pixel[29:24], 2'b11};
            a_out = AlphaFull;
        end
    end

    // per channel weighted and saturating sums
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [7:0] t;
            logic [7:0] b;
            logic [8:0] s;
            t = i_pixel[c*8 +: 8];
            b = i_below[c*8 +: 8];
            wch[c] = div255(16'(t) * 16'(w)) + div255(16'(b) * 16'(8'hFF - w));
            s = {1'b0, t} + {1'b0, b};
            sch[c] = s[8] ? 8'hFF : s[7:0];
        end
    end

    // select pass, empty or blend
    always_comb begin
        if (i_pixel == '0) begin
            o_pixel = i_below;
        end else if (!transp) begin
            o_pixel = i_pixel;
        end else if (i_mode == ModeSatAdd) begin
            o_pixel = {2'b00, AlphaFull, sch[2], sch[1], sch[0]};
        end else begin
            o_pixel = {2'b00, a_out, wch[2], wch[1], wch[0]};
        end
    end

endmodule

[test/tb_top.sv]
// testbench for the priority layer pixel compositor
// predicts each composite and display pixel in the bench and checks every result strobe
// depends on plc_pkg and priority_layer_pixel_compositor_top
module tb_top;
    import plc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in        i_data;
    logic       o_valid;
    t_out       o_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [1:0] i_cfg_data;

    logic [1:0] cur_mode;
    logic [1:0] cur_fmt;
    t_out       pending_pixels[$];
    int         fail_cnt;
    bit         idle_on;

    priority_layer_pixel_compositor_top #(.NUM_LAYERS(8)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_data(i_data),
        .o_valid(o_valid), .o_data(o_data), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // transparency test under the current blend mode
    function automatic bit see_through(logic [31:0] p);
        if (cur_mode == ModeAlphaBot || cur_mode == ModeSatAdd) begin
            return p[31];
        end
        return p[29:24] != AlphaFull;
    endfunction

    // weighted per-channel mix, truncated quotients
    function automatic logic [31:0] mix_weighted(logic [31:0] top, logic [31:0] bot,
                                                 int unsigned w, logic [5:0] a_out);
        logic [31:0] r;
        int unsigned c;
        r = {2'b00, a_out, 24'h0};
        for (int sh = 0; sh <= 16; sh += 8) begin
            c = (((top >> sh) & 32'hFF) * w) / 255 + (((bot >> sh) & 32'hFF) * (255 - w)) / 255;
            r |= (c & 32'hFF) << sh;
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_pixels(logic [31:0] top, logic [31:0] bot);
        logic [31:0] r;
        int unsigned c;
        if (cur_mode == ModeAlphaBot) begin
            if (!top[31]) begin
                return top;
            end
            return mix_weighted(top, bot, bot[29:24] * 4 + 3, top[29:24]);
        end
        if (cur_mode == ModeSatAdd) begin
            r = {2'b00, AlphaFull, 24'h0};
            for (int sh = 0; sh <= 16; sh += 8) begin
                c = ((top >> sh) & 32'hFF) + ((bot >> sh) & 32'hFF);
                if (c > 255) c = 255;
                r |= c << sh;
            end
            return r;
        end
        return mix_weighted(top, bot, top[29:24] * 4 + 3, AlphaFull);
    endfunction

    // composite of layers 0..top_layer, highest non-empty pixel first
    function automatic logic [31:0] stack_pixel(logic [31:0] lay[8], int top_layer);
        int p;
        p = top_layer;
        while (p >= 0 && lay[p] == 32'h0) p--;
        if (p < 0) begin
            return 32'h0;
        end
        if (p == 0 || !see_through(lay[p])) begin
            return lay[p];
        end
        return mix_pixels(lay[p], stack_pixel(lay, p - 1));
    endfunction

    function automatic t_out predict_pixel(t_in d);
        logic [31:0] lay[8];
        logic [31:0] c;
        t_out r;
        lay = '{d.layer0_pixel, d.layer1_pixel, d.layer2_pixel, d.layer3_pixel,
                d.layer4_pixel, d.layer5_pixel, d.layer6_pixel, d.layer7_pixel};
        c = stack_pixel(lay, 7);
        r.composed_pixel = c;
        r.pixel_present = c != 0;
        if (c == 0) begin
            r.display_pixel = 0;
        end else if (cur_fmt == FmtRgb555) begin
            r.display_pixel = ((c >> 3) & 32'h1F) | ((c >> 6) & 32'h3E0) | ((c >> 9) & 32'h7C00);
        end else if (cur_fmt == FmtRgb565) begin
            r.display_pixel = ((c >> 3) & 32'h1F) | ((c >> 5) & 32'h7E0) | ((c >> 8) & 32'hF800);
        end else begin
            r.display_pixel = (((c & 32'h3F000000) << 2) + 32'h03000000) | (c & 32'h00FFFFFF);
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result composed_pixel=%h", o_data.composed_pixel);
                fail_cnt++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_data.composed_pixel !== want.composed_pixel) begin
                    $error("composed_pixel exp %h got %h", want.composed_pixel,
                           o_data.composed_pixel);
                    fail_cnt++;
                end
                if (o_data.display_pixel !== want.display_pixel) begin
                    $error("display_pixel exp %h got %h", want.display_pixel,
                           o_data.display_pixel);
                    fail_cnt++;
                end
                if (o_data.pixel_present !== want.pixel_present) begin
                    $error("pixel_present exp %b got %b", want.pixel_present,
                           o_data.pixel_present);
                    fail_cnt++;
                end
            end
        end
    end

    // send one transaction, with random idle cycles before it
    task automatic send_pixels(t_in d);
        while (idle_on && $urandom_range(99) < 14) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels.push_back(predict_pixel(d));
    endtask

    // wait for every expected result, then let the pipeline empty
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegBlendMode) cur_mode = val;
        else cur_fmt = val;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_layer_px();
        case ($urandom_range(7))
            0, 1: return 32'h0;
            2: return {1'b1, 1'($urandom_range(1)), 6'($urandom_range(63)), 24'($urandom)};
            3: return {2'($urandom_range(3)), AlphaFull, 24'($urandom)};
            4: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in d;
        d = {rand_layer_px(), rand_layer_px(), rand_layer_px(), rand_layer_px(),
             rand_layer_px(), rand_layer_px(), rand_layer_px(), rand_layer_px()};
        return d;
    endfunction

    // directed corner cases under the given settings
    task automatic test_directed();
        t_in d;
        d = '0;
        send_pixels(d);
        d.layer0_pixel = 32'hBFFF_FFFF;
        send_pixels(d);
        d = '0;
        d.layer0_pixel = 32'h8012_3456;
        send_pixels(d);
        d.layer5_pixel = 32'h8A40_80FF;
        send_pixels(d);
        d = '0;
        d.layer7_pixel = 32'h8000_FFFF;
        send_pixels(d);
        d.layer7_pixel = 32'hFFFF_FFFF;
        send_pixels(d);
        d.layer7_pixel = 32'h7FFF_FFFF;
        send_pixels(d);
        d = {8{32'h9020_C080}};
        send_pixels(d);
        d = {32'h0000_0001, 32'h0, 32'hC5FF_0000, 32'h0, 32'h8100_FF00,
             32'h3F00_0000, 32'h0, 32'h8AFF_FFFF};
        send_pixels(d);
    endtask

    task automatic test_settings();
        for (int m = 0; m < 4; m++) begin
            for (int f = 0; f < 4; f++) begin
                write_reg(RegBlendMode, 2'(m));
                write_reg(RegOutFormat, 2'(f));
                test_directed();
                drain();
            end
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(RegBlendMode, 2'($urandom_range(3)));
            write_reg(RegOutFormat, 2'($urandom_range(3)));
            idle_on = (ph != 3);
            for (int k = 0; k < 180; k++) begin
                send_pixels(rand_item());
            end
            drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = RegBlendMode;
        i_cfg_data = 2'd0;
        cur_mode   = ModeAlphaTop;
        cur_fmt    = FmtArgb8888;
        fail_cnt   = 0;
        idle_on    = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        test_settings();
        test_random();
        drain();
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // timeout
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end
endmodule
